### rtl/ibe_pkg.sv
// ibe_pkg: shared types and constants for the I2C master bit engine.
// Holds the input/result beat structs, command codes and reset constants.
// No dependencies.
package ibe_pkg;

  localparam int unsigned DelayWidth = 16;
  localparam logic [DelayWidth-1:0] BitDelayReset = 16'd15;
  localparam int unsigned ByteBits = 8;

  // command codes carried on op
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] wr_data;
    logic       ack_level;
    logic       scl_in;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       nack;
  } out_item_t;

endpackage

### rtl/i2c_master_bit_engine.sv
// A result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; each beat is one bus timer tick and
// all of its work sits between the state registers and the result register.
// The input side stalls only while a finished result waits for out_ready_i.
// Reset (rst_ni low, asynchronous): idle, both lines released, bit_delay 15,
// no result pending.
module i2c_master_bit_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ibe_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ibe_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ibe_pkg::DelayWidth-1:0]      cfg_wdata_i
);
  import ibe_pkg::*;

  // state
  cmd_e                  cmd_q, cmd_d;
  logic [3:0]            bit_cnt_q, bit_cnt_d;
  logic [1:0]            phase_q, phase_d;
  logic [DelayWidth-1:0] dly_q, dly_d;
  logic [ByteBits-1:0]   shift_q, shift_d;
  logic                  scl_drv_q, scl_drv_d;
  logic                  sda_drv_q, sda_drv_d;
  logic                  ack_flag_q, ack_flag_d;
  logic                  ack_drv_q, ack_drv_d;
  logic [ByteBits-1:0]   rd_byte_q, rd_byte_d;
  logic [DelayWidth-1:0] bit_delay_q;
  logic                  out_valid_q;
  out_item_t             out_q, out_d;

  logic                  in_fire;
  logic                  done;
  logic [DelayWidth-1:0] bd;
  logic [DelayWidth:0]   dly_inc;
  logic                  mon, hold;
  logic [1:0]            drv;

  // true when the current byte bit is driven by the master
  function automatic logic bit_is_write(cmd_e cmd, logic [3:0] bc);
    if (cmd == CMD_WRITE) return bc < 4'd8;
    return bc >= 4'd8;
  endfunction

  // line drives on entering a phase, returned as {scl, sda}
  function automatic logic [1:0] enter_drv(cmd_e cmd, logic [1:0] ph, logic [3:0] bc,
                                           logic [7:0] sh, logic ackd,
                                           logic scl, logic sda);
    logic s_c;
    logic s_d;
    s_c = scl;
    s_d = sda;
    case (cmd)
      CMD_START: begin
        if (ph == 2'd0) s_d = 1'b1; else s_c = 1'b1;
      end
      CMD_STOP: begin
        if (ph == 2'd0) s_d = 1'b1;
        else if (ph == 2'd1) s_c = 1'b0;
        else s_d = 1'b0;
      end
      default: begin
        if (ph == 2'd0) begin
          if (!bit_is_write(cmd, bc)) s_d = 1'b0;
          else if (cmd == CMD_WRITE) s_d = ~sh[ByteBits-1];
          else s_d = ~ackd;
        end else if (ph == 2'd1) begin
          s_c = 1'b0;
        end else begin
          s_c = 1'b1;
        end
      end
    endcase
    return {s_c, s_d};
  endfunction

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // one bus tick of the phase sequencer
  always_comb begin
    cmd_d      = cmd_q;
    bit_cnt_d  = bit_cnt_q;
    phase_d    = phase_q;
    dly_d      = dly_q;
    shift_d    = shift_q;
    scl_drv_d  = scl_drv_q;
    sda_drv_d  = sda_drv_q;
    ack_flag_d = ack_flag_q;
    ack_drv_d  = ack_drv_q;
    rd_byte_d  = rd_byte_q;
    done       = 1'b0;
    drv        = {scl_drv_q, sda_drv_q};
    bd         = (bit_delay_q == '0) ? DelayWidth'(1) : bit_delay_q;
    mon        = (cmd_q != CMD_START) && (phase_q == 2'd1);
    dly_inc    = {1'b0, dly_q} + (DelayWidth+1)'(1);
    hold       = mon && !in_data_i.scl_in &&
                 ((dly_q == '0) || (dly_inc >= {1'b0, bd}));

    if (cmd_q == CMD_IDLE) begin
      if (in_data_i.op inside {[CMD_START:CMD_STOP]}) begin
        cmd_d     = cmd_e'(in_data_i.op);
        bit_cnt_d = '0;
        phase_d   = '0;
        if (cmd_d == CMD_WRITE) shift_d = in_data_i.wr_data;
        if (cmd_d == CMD_READ) begin
          shift_d   = '0;
          ack_drv_d = in_data_i.ack_level;
        end
        drv   = enter_drv(cmd_d, 2'd0, 4'd0, shift_d, ack_drv_d, scl_drv_q, sda_drv_q);
        dly_d = '0;
      end
    end else if (!hold) begin
      dly_d = dly_inc[DelayWidth-1:0];
      if (dly_d >= bd) begin
        case (cmd_q)
          CMD_START: begin
            if (phase_q == 2'd0) begin
              phase_d = 2'd1;
              drv     = enter_drv(cmd_q, phase_d, bit_cnt_q, shift_q, ack_drv_q,
                                  scl_drv_q, sda_drv_q);
              dly_d   = '0;
            end else begin
              cmd_d     = CMD_IDLE;
              bit_cnt_d = '0;
              phase_d   = '0;
              dly_d     = '0;
              done      = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_q < 2'd2) begin
              phase_d = phase_q + 2'd1;
              drv     = enter_drv(cmd_q, phase_d, bit_cnt_q, shift_q, ack_drv_q,
                                  scl_drv_q, sda_drv_q);
              dly_d   = '0;
            end else begin
              cmd_d     = CMD_IDLE;
              bit_cnt_d = '0;
              phase_d   = '0;
              dly_d     = '0;
              done      = 1'b1;
            end
          end
          default: begin
            // sample SDA at the end of SCL high on a slave-driven bit
            if (phase_q == 2'd1 && !bit_is_write(cmd_q, bit_cnt_q)) begin
              if (cmd_q == CMD_READ) shift_d = {shift_q[ByteBits-2:0], in_data_i.sda_in};
              else ack_flag_d = in_data_i.sda_in;
            end
            if (phase_q < 2'd2) begin
              phase_d = phase_q + 2'd1;
              drv     = enter_drv(cmd_q, phase_d, bit_cnt_q, shift_d, ack_drv_q,
                                  scl_drv_q, sda_drv_q);
              dly_d   = '0;
            end else begin
              if (cmd_q == CMD_WRITE && bit_cnt_q < 4'd8)
                shift_d = {shift_q[ByteBits-2:0], 1'b0};
              if (bit_cnt_q >= 4'd8) begin
                if (cmd_q == CMD_READ) rd_byte_d = shift_d;
                cmd_d     = CMD_IDLE;
                bit_cnt_d = '0;
                phase_d   = '0;
                dly_d     = '0;
                done      = 1'b1;
              end else begin
                bit_cnt_d = bit_cnt_q + 4'd1;
                phase_d   = '0;
                drv       = enter_drv(cmd_q, 2'd0, bit_cnt_d, shift_d, ack_drv_q,
                                      scl_drv_q, sda_drv_q);
                dly_d     = '0;
              end
            end
          end
        endcase
      end
    end

    scl_drv_d = drv[1];
    sda_drv_d = drv[0];

    out_d.scl_low  = scl_drv_d;
    out_d.sda_low  = sda_drv_d;
    out_d.busy_res = (cmd_d != CMD_IDLE);
    out_d.done_res = done;
    out_d.rd_data  = rd_byte_d;
    out_d.nack     = ack_flag_d;
  end

  // state, config and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_IDLE;
      bit_cnt_q   <= '0;
      phase_q     <= '0;
      dly_q       <= '0;
      shift_q     <= '0;
      scl_drv_q   <= 1'b0;
      sda_drv_q   <= 1'b0;
      ack_flag_q  <= 1'b0;
      ack_drv_q   <= 1'b0;
      rd_byte_q   <= '0;
      bit_delay_q <= BitDelayReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) bit_delay_q <= cfg_wdata_i;
      if (in_fire) begin
        cmd_q      <= cmd_d;
        bit_cnt_q  <= bit_cnt_d;
        phase_q    <= phase_d;
        dly_q      <= dly_d;
        shift_q    <= shift_d;
        scl_drv_q  <= scl_drv_d;
        sda_drv_q  <= sda_drv_d;
        ack_flag_q <= ack_flag_d;
        ack_drv_q  <= ack_drv_d;
        rd_byte_q  <= rd_byte_d;
      end
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

endmodule

### rtl/ibe_checker.sv
// ibe_assert_checker: port-level assertions for i2c_master_bit_engine, plus its bind.
// Depends on ibe_pkg for the beat structs.
module ibe_assert_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input ibe_pkg::out_item_t             out_data_o
);
  import ibe_pkg::*;

  // every accepted beat yields a result beat next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // input is ready only while no result waits untaken
  a_ready_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input accepted over an untaken result");

  // a completed command leaves the engine idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

endmodule

bind i2c_master_bit_engine ibe_assert_checker u_ibe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### sim/ibe_checker.sv
// ibe_checker: watches the input, result and config ports of the I2C master bit engine,
// predicts every result beat from the accepted tick beats and compares field by field.
// Depends on ibe_pkg for the beat structs and command codes.
module ibe_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  ibe_pkg::in_item_t              in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  ibe_pkg::out_item_t             out_data_i,
  input  logic                           cfg_we_i,
  input  logic [ibe_pkg::DelayWidth-1:0] cfg_wdata_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o,
  output logic                           busy_o,
  output int unsigned                    ticks_o,
  output int unsigned                    done_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ibe_pkg::*;

  localparam int unsigned PrintCap = 60;

  // predicted engine state
  logic [DelayWidth-1:0] half_bit;
  cmd_e                  cur_cmd;
  logic [3:0]            bit_idx;
  logic [2:0]            phase;
  logic [DelayWidth-1:0] tick_cnt;
  logic [7:0]            shifter;
  logic                  scl_pull;
  logic                  sda_pull;
  logic                  nack_flag;
  logic                  ack_hold;
  logic [7:0]            rx_byte;

  out_item_t             line_state_q[$];
  int unsigned           beat_no;

  task automatic log_error(input string msg);
    if (fail_count_o < PrintCap) $display("[%0t] ERROR: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want)
      log_error($sformatf("result beat %0d, %s: got 0x%0h, want 0x%0h", beat_no, name, got, want));
  endtask

  // current bit of a byte command has the master driving SDA
  function automatic logic master_owns_sda();
    if (cur_cmd == CMD_WRITE) return bit_idx < 4'd8;
    return bit_idx >= 4'd8;
  endfunction

  // apply the line drives of the phase just entered and restart the count
  task automatic enter_phase();
    case (cur_cmd)
      CMD_START: begin
        if (phase == 3'd0) sda_pull = 1'b1;
        else scl_pull = 1'b1;
      end
      CMD_STOP: begin
        if (phase == 3'd0) sda_pull = 1'b1;
        else if (phase == 3'd1) scl_pull = 1'b0;
        else sda_pull = 1'b0;
      end
      default: begin
        if (phase == 3'd0) begin
          if (!master_owns_sda()) sda_pull = 1'b0;
          else if (cur_cmd == CMD_WRITE) sda_pull = ~shifter[7];
          else sda_pull = ~ack_hold;
        end else if (phase == 3'd1) begin
          scl_pull = 1'b0;
        end else begin
          scl_pull = 1'b1;
        end
      end
    endcase
    tick_cnt = '0;
  endtask

  task automatic end_cmd();
    cur_cmd  = CMD_IDLE;
    bit_idx  = '0;
    phase    = '0;
    tick_cnt = '0;
  endtask

  // one bus tick: returns the line drives and status after the tick
  task automatic predict_bus_tick(input in_item_t b, output out_item_t r);
    int unsigned span;
    logic        watch_scl;
    logic        stall;
    logic        fin;
    fin = 1'b0;
    if (cur_cmd == CMD_IDLE) begin
      if (b.op >= CMD_START && b.op <= CMD_STOP) begin
        cur_cmd = cmd_e'(b.op);
        bit_idx = '0;
        phase   = '0;
        if (cur_cmd == CMD_WRITE) shifter = b.wr_data;
        if (cur_cmd == CMD_READ) begin
          shifter  = '0;
          ack_hold = b.ack_level;
        end
        enter_phase();
      end
    end else begin
      // a zero delay counts as one tick
      span      = (half_bit == '0) ? 1 : half_bit;
      watch_scl = (cur_cmd != CMD_START) && (phase == 3'd1);
      // clock stretching: hold the first and last tick until SCL reads high
      stall = watch_scl && !b.scl_in && (tick_cnt == '0 || tick_cnt + 1 >= span);
      if (!stall) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= span) begin
          case (cur_cmd)
            CMD_START: begin
              if (phase == 3'd0) begin
                phase = 3'd1;
                enter_phase();
              end else begin
                end_cmd();
                fin = 1'b1;
              end
            end
            CMD_STOP: begin
              if (phase < 3'd2) begin
                phase++;
                enter_phase();
              end else begin
                end_cmd();
                fin = 1'b1;
              end
            end
            default: begin
              // sample SDA at the end of SCL high when the slave owns the bit
              if (phase == 3'd1 && !master_owns_sda()) begin
                if (cur_cmd == CMD_READ) shifter = {shifter[6:0], b.sda_in};
                else nack_flag = b.sda_in;
              end
              if (phase < 3'd2) begin
                phase++;
                enter_phase();
              end else begin
                if (cur_cmd == CMD_WRITE && bit_idx < 4'd8) shifter = shifter << 1;
                if (bit_idx >= 4'd8) begin
                  if (cur_cmd == CMD_READ) rx_byte = shifter;
                  end_cmd();
                  fin = 1'b1;
                end else begin
                  bit_idx++;
                  phase = 3'd0;
                  enter_phase();
                end
              end
            end
          endcase
        end
      end
    end
    r.scl_low  = scl_pull;
    r.sda_low  = sda_pull;
    r.busy_res = (cur_cmd != CMD_IDLE);
    r.done_res = fin;
    r.rd_data  = rx_byte;
    r.nack     = nack_flag;
  endtask

  // watch the ports on each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t next;
    if (!rst_ni) begin
      half_bit  = BitDelayReset;
      cur_cmd   = CMD_IDLE;
      bit_idx   = '0;
      phase     = '0;
      tick_cnt  = '0;
      shifter   = '0;
      scl_pull  = 1'b0;
      sda_pull  = 1'b0;
      nack_flag = 1'b0;
      ack_hold  = 1'b0;
      rx_byte   = '0;
      line_state_q.delete();
      beat_no      = 0;
      fail_count_o = 0;
      pending_o    = 0;
      busy_o       = 1'b0;
      ticks_o      = 0;
      done_cnt_o   = 0;
    end else begin
      if (cfg_we_i) half_bit = cfg_wdata_i;
      // result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (line_state_q.size() == 0) begin
          log_error($sformatf("result beat %0d arrived with nothing expected", beat_no));
        end else begin
          want = line_state_q.pop_front();
          check_field("scl_low", 8'(want.scl_low), 8'(out_data_i.scl_low));
          check_field("sda_low", 8'(want.sda_low), 8'(out_data_i.sda_low));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data_i.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_data_i.done_res));
          check_field("rd_data", want.rd_data, out_data_i.rd_data);
          check_field("nack", 8'(want.nack), 8'(out_data_i.nack));
        end
        beat_no++;
      end
      // tick beat: predict its result
      if (in_valid_i && in_ready_i) begin
        predict_bus_tick(in_data_i, next);
        line_state_q.push_back(next);
        ticks_o++;
        if (next.done_res) done_cnt_o++;
      end
      pending_o = line_state_q.size();
      busy_o    = (cur_cmd != CMD_IDLE);
    end
  end

endmodule

### sim/tb.sv
// tb: stimulus and verdict for the I2C master bit engine.
// Drives bus ticks, commands and bit_delay settings; checking is done by ibe_checker.
// Depends on ibe_pkg, i2c_master_bit_engine and ibe_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibe_pkg::*;

  localparam int unsigned CycleLimit    = 2_000_000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandTicks     = 600;
  localparam int unsigned RandPhases    = 5;
  localparam logic [2:0]  OpBadLo       = 3'd5;
  localparam logic [2:0]  OpBadHi       = 3'd7;

  typedef enum logic [1:0] {SDA_ZERO, SDA_ONE, SDA_RAND} sda_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [DelayWidth-1:0] cfg_wdata;

  int unsigned           chk_fails;
  int unsigned           chk_pending;
  logic                  chk_busy;
  int unsigned           chk_ticks;
  int unsigned           chk_dones;

  bit                    quiet;
  bit                    squeeze_req;
  int unsigned           cycle_cnt = 0;

  always #6 clk = ~clk;

  i2c_master_bit_engine dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  ibe_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (chk_fails),
    .pending_o    (chk_pending),
    .busy_o       (chk_busy),
    .ticks_o      (chk_ticks),
    .done_cnt_o   (chk_dones)
  );

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic pick_sda(input sda_mode_e mode);
    case (mode)
      SDA_ZERO: return 1'b0;
      SDA_ONE:  return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // offer one tick beat; entered and left at a falling edge
  task automatic put_tick(input in_item_t b);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // issue a command, then feed ticks until the engine goes idle; noisy ticks
  // carry ignored ops and SCL held low by a stretching slave
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] wr, input logic ack,
                         input sda_mode_e mode, input bit noisy);
    in_item_t b;
    b.op        = op;
    b.wr_data   = wr;
    b.ack_level = ack;
    b.scl_in    = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
    b.sda_in    = pick_sda(mode);
    put_tick(b);
    while (chk_busy) begin
      b.op        = noisy ? 3'($urandom_range(0, 7)) : CMD_IDLE;
      b.wr_data   = 8'($urandom);
      b.ack_level = 1'($urandom_range(0, 1));
      b.scl_in    = noisy ? ($urandom_range(0, 4) != 0) : 1'b1;
      b.sda_in    = pick_sda(mode);
      put_tick(b);
    end
  endtask

  // let the engine go idle and every result drain
  task automatic settle();
    in_item_t b;
    b        = '0;
    b.scl_in = 1'b1;
    while (chk_busy) put_tick(b);
    in_valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic load_bit_delay(input logic [DelayWidth-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random command mix with random content
  task automatic random_cmd();
    int unsigned r;
    logic [2:0]  op;
    r = $urandom_range(0, 99);
    if (r < 15) op = CMD_START;
    else if (r < 45) op = CMD_WRITE;
    else if (r < 75) op = CMD_READ;
    else if (r < 90) op = CMD_STOP;
    else if (r < 95) op = CMD_IDLE;
    else op = 3'($urandom_range(OpBadLo, OpBadHi));
    quiet = ($urandom_range(0, 4) == 0);
    run_cmd(op, 8'($urandom), 1'($urandom_range(0, 1)),
            sda_mode_e'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned held;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        out_ready <= 1'b0;
        for (held = 0; held < HoldOffCycles; held++) @(negedge clk);
        squeeze_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // run limit
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_cnt);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main stimulus
  initial begin
    int          op;
    int unsigned target;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    quiet       = 1'b0;
    squeeze_req = 1'b0;
    rst_n       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default timing after reset
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
    settle();

    // directed: fastest timing, field extremes, every op
    load_bit_delay(16'd1);
    for (op = OpBadLo; op <= OpBadHi; op++) run_cmd(3'(op), 8'hFF, 1'b1, SDA_ONE, 1'b0);
    run_cmd(CMD_IDLE, 8'h00, 1'b0, SDA_ZERO, 1'b0);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_ONE, 1'b0);
    run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_ONE, 1'b0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_ZERO, 1'b0);
    run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b1);
    run_cmd(CMD_READ, 8'h00, 1'b0, SDA_ONE, 1'b0);
    run_cmd(CMD_READ, 8'hFF, 1'b1, SDA_ZERO, 1'b0);
    run_cmd(CMD_READ, 8'h3C, 1'b0, SDA_RAND, 1'b1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
    run_cmd(CMD_STOP, 8'h00, 1'b1, SDA_RAND, 1'b1);
    settle();

    // zero delay behaves as one tick
    load_bit_delay(16'd0);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
    run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b1);
    run_cmd(CMD_READ, 8'h00, 1'b1, SDA_RAND, 1'b1);
    run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
    settle();

    // longer delay: a single start, no idling
    quiet = 1'b1;
    load_bit_delay(16'd100);
    run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
    settle();
    quiet = 1'b0;

    // random phases at short delays; the first one carries the long hold-off
    target = chk_ticks;
    for (int ph = 0; ph < RandPhases; ph++) begin
      load_bit_delay(16'($urandom_range(1, 4)));
      if (ph == 0) squeeze_req = 1'b1;
      target += RandTicks / RandPhases;
      while (chk_ticks < target) random_cmd();
      quiet = 1'b0;
      settle();
    end

    $display("Run covered %0d bus ticks and %0d completed commands, with bit_delay at",
             chk_ticks, chk_dones);
    $display("reset value, 0, 1, 100 and random short values, plus one long result hold-off");
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ibe_pkg.sv
rtl/i2c_master_bit_engine.sv
rtl/ibe_checker.sv
sim/ibe_checker.sv
sim/tb.sv
